// ----- rtl/core/lrf_pkg.sv -----
// Shared constants, codes and the front-to-back command type of the log record framer.
`timescale 1ns / 1ps

package lrf_pkg;

    // Marker message area size and the counter widths that follow from it
    localparam int MESSAGE_BYTES = 50;
    localparam int MSG_CNT_W     = $clog2(MESSAGE_BYTES + 1);
    localparam int PREFIX_BYTES  = 4;
    localparam int POS_W         = $clog2(PREFIX_BYTES + 1 + MESSAGE_BYTES + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Record kinds and their type bytes
    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_MARKER = 1'b1;
    localparam logic [7:0] TYPE_DATA   = 8'h00;
    localparam logic [7:0] TYPE_MARKER = 8'h01;
    localparam logic [7:0] PAD_BYTE    = 8'h00;
    localparam logic [7:0] NUL_BYTE    = 8'h00;

    // One classified input item: prefix, optional payload byte, repeated trailer byte
    typedef struct packed {
        logic                 has_pre;
        logic [7:0]           pre_type;
        logic [7:0]           counter;
        logic [15:0]          timestamp;
        logic                 has_byte;
        logic [7:0]           data_byte;
        logic                 byte_end;
        logic [MSG_CNT_W-1:0] trl_cnt;
        logic [7:0]           trl_val;
    } t_cmd;

endpackage

// ----- rtl/core/lrf_front.sv -----
// Front end: accepts items, tracks record state and turns each item into a command.
`timescale 1ns / 1ps

module lrf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // counter[7:0], timestamp[23:8], payload_byte[31:24]
    input  logic [1:0]        i_s_tuser,   // mode[0], byte_present[1]
    input  logic              i_s_tlast,
    input  logic              i_q_full,
    output logic              o_push,
    output lrf_pkg::t_cmd     o_cmd
);

    logic                          r_in_record, n_in_record;
    logic                          r_kind, n_kind;
    logic [7:0]                    r_sum, n_sum;
    logic [lrf_pkg::MSG_CNT_W-1:0] r_count, n_count;
    logic                          r_ended, n_ended;

    logic                          first;
    logic                          kind;
    logic [7:0]                    sum0;
    logic [lrf_pkg::MSG_CNT_W-1:0] cnt0;
    logic [lrf_pkg::MSG_CNT_W-1:0] cnt1;
    logic                          ended0;
    logic                          take;
    logic                          accept;
    logic                          present;
    logic                          last;
    logic [7:0]                    pb;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;
    assign present    = i_s_tuser[1];
    assign last       = i_s_tlast;
    assign pb         = i_s_tdata[31:24];

    // Classify the item against the current record state
    always_comb begin
        first  = !r_in_record;
        kind   = first ? i_s_tuser[0] : r_kind;
        sum0   = first ? 8'h00 : r_sum;
        cnt0   = first ? '0 : r_count;
        ended0 = first ? 1'b0 : r_ended;

        take = (kind == lrf_pkg::KIND_MARKER) && present && !ended0
            && (cnt0 < lrf_pkg::MSG_CNT_W'(lrf_pkg::MESSAGE_BYTES));
        cnt1 = cnt0 + lrf_pkg::MSG_CNT_W'(take);

        n_sum   = sum0 + ((kind == lrf_pkg::KIND_DATA && present) ? pb : 8'h00);
        n_count = cnt1;
        n_ended = ended0 | (take && (pb == lrf_pkg::NUL_BYTE));

        o_cmd.has_pre   = first;
        o_cmd.pre_type  = (kind == lrf_pkg::KIND_MARKER) ? lrf_pkg::TYPE_MARKER
                                                         : lrf_pkg::TYPE_DATA;
        o_cmd.counter   = i_s_tdata[7:0];
        o_cmd.timestamp = i_s_tdata[23:8];
        o_cmd.data_byte = pb;

        if (kind == lrf_pkg::KIND_DATA) begin
            o_cmd.has_byte = present;
            o_cmd.byte_end = 1'b0;
            o_cmd.trl_cnt  = last ? lrf_pkg::MSG_CNT_W'(1) : '0;
            o_cmd.trl_val  = n_sum;
        end else begin
            o_cmd.has_byte = take;
            o_cmd.byte_end = take && (cnt1 == lrf_pkg::MSG_CNT_W'(lrf_pkg::MESSAGE_BYTES));
            o_cmd.trl_cnt  = last ? lrf_pkg::MSG_CNT_W'(lrf_pkg::MESSAGE_BYTES) - cnt1 : '0;
            o_cmd.trl_val  = lrf_pkg::PAD_BYTE;
        end

        // Close the record on the last item
        n_in_record = !last;
        n_kind      = kind;
        if (last) begin
            n_sum   = 8'h00;
            n_count = '0;
            n_ended = 1'b0;
        end
    end

    // Drop items that give no bytes
    assign o_push = accept && (o_cmd.has_pre || o_cmd.has_byte || (o_cmd.trl_cnt != '0));

    // Record state advances on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_record <= 1'b0;
            r_kind      <= lrf_pkg::KIND_DATA;
            r_sum       <= 8'h00;
            r_count     <= '0;
            r_ended     <= 1'b0;
        end else if (accept) begin
            r_in_record <= n_in_record;
            r_kind      <= n_kind;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_ended     <= n_ended;
        end
    end

endmodule

// ----- rtl/core/lrf_queue.sv -----
// Short command queue that decouples the front end from the byte sequencer.
`timescale 1ns / 1ps

module lrf_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  lrf_pkg::t_cmd                i_cmd,
    input  logic                         i_pop,
    output lrf_pkg::t_cmd                o_head,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [lrf_pkg::QUEUE_CW-1:0] o_count
);

    lrf_pkg::t_cmd                r_mem [lrf_pkg::QUEUE_DEPTH];
    logic [lrf_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [lrf_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [lrf_pkg::QUEUE_CW-1:0] r_count, n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == lrf_pkg::QUEUE_CW'(lrf_pkg::QUEUE_DEPTH));
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + lrf_pkg::QUEUE_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - lrf_pkg::QUEUE_CW'(1);
        end
    end

    // Store commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + lrf_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + lrf_pkg::QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/core/lrf_back.sv -----
// Back end: expands the head command into output register bytes, one per cycle unless stalled.
`timescale 1ns / 1ps

module lrf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lrf_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,   // out_byte[7:0]
    output logic          o_m_tlast,
    output logic          o_m_tuser    // run_last[0]
);

    logic [lrf_pkg::POS_W-1:0] r_pos;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_end;
    logic                      r_run_last;

    logic                      out_free;
    logic                      emit;
    logic [lrf_pkg::POS_W-1:0] pre_n;
    logic [lrf_pkg::POS_W-1:0] total;
    logic                      in_pre;
    logic                      in_byte;
    logic                      is_last;
    logic [7:0]                cur_byte;
    logic                      cur_end;

    assign out_free = !r_valid || i_m_tready;
    assign emit     = out_free && !i_empty;
    assign o_pop    = emit && is_last;

    // Pick the byte at the current position of the head command
    always_comb begin
        pre_n   = i_head.has_pre ? lrf_pkg::POS_W'(lrf_pkg::PREFIX_BYTES) : '0;
        total   = pre_n + lrf_pkg::POS_W'(i_head.has_byte)
                + lrf_pkg::POS_W'(i_head.trl_cnt);
        is_last = (r_pos == total - lrf_pkg::POS_W'(1));
        in_pre  = i_head.has_pre && (r_pos < lrf_pkg::POS_W'(lrf_pkg::PREFIX_BYTES));
        in_byte = !in_pre && i_head.has_byte && (r_pos == pre_n);

        if (in_pre) begin
            case (r_pos[1:0])
                2'd0:    cur_byte = i_head.pre_type;
                2'd1:    cur_byte = i_head.counter;
                2'd2:    cur_byte = i_head.timestamp[15:8];
                2'd3:    cur_byte = i_head.timestamp[7:0];
                default: cur_byte = i_head.pre_type;
            endcase
            cur_end = 1'b0;
        end else if (in_byte) begin
            cur_byte = i_head.data_byte;
            cur_end  = i_head.byte_end;
        end else begin
            cur_byte = i_head.trl_val;
            cur_end  = is_last;
        end
    end

    // Step through the command and retire it on its last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= !i_empty;
            if (emit) begin
                r_pos <= is_last ? '0 : r_pos + lrf_pkg::POS_W'(1);
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte     <= cur_byte;
            r_end      <= cur_end;
            r_run_last <= is_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_end;
    assign o_m_tuser  = r_run_last;

endmodule

// ----- rtl/core/log_record_framer_core.sv -----
// Top level of the log record framer: front end, command queue and byte sequencer.
// Path: the first output byte of an accepted item passes through the command queue and then the output register.
// Throughput: one item per cycle while each item gives one byte and the output does not stall; an item occupies the
// output sequencer until every byte it gives is sent (prefix 4, marker padding up to 50).
// Reset: synchronous active-low i_rst_n clears record state, queue and output valid.
`timescale 1ns / 1ps

module log_record_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // counter[7:0], timestamp[23:8], payload_byte[31:24]
    input  logic [1:0]  i_s_tuser,   // mode[0], byte_present[1]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte[7:0]
    output logic        o_m_tlast,
    output logic        o_m_tuser    // run_last[0]
);

    lrf_pkg::t_cmd                w_cmd;
    lrf_pkg::t_cmd                w_head;
    logic                         w_push;
    logic                         w_pop;
    logic                         w_empty;
    logic                         w_full;
    logic [lrf_pkg::QUEUE_CW-1:0] w_count;

    lrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    lrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_count (w_count)
    );

    lrf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef ASSERT_OFF
    // A record's final byte always closes the run of its item
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser)
        else $error("record end without run end");

    // Sequencer retires only commands that exist
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_count != '0))
        else $error("queue pop while empty");

    // Fill level never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_count != lrf_pkg::QUEUE_CW'(lrf_pkg::QUEUE_DEPTH)))
        else $error("queue push while full");

    // Output is idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ----- tb/tb_log_record_framer_core.sv -----
// Self-checking testbench for the log record framer core with its own byte-level framing predictor.
`timescale 1ns / 1ps

module tb_log_record_framer_core;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int BURST_MAX = 64;

    // One input item as the sender sees it
    typedef struct {
        logic       mode;
        logic [7:0] counter;
        logic [15:0] stamp;
        logic [7:0] pb;
        logic       present;
        logic       last;
    } t_log_item;

    // One framed output byte with its flags
    typedef struct {
        logic [7:0] value;
        logic       rec_end;
        logic       run_end;
    } t_wire_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // counter[7:0], timestamp[23:8], payload_byte[31:24]
    logic [1:0]  i_s_tuser = '0;   // mode[0], byte_present[1]
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // out_byte[7:0]
    logic        o_m_tlast;
    logic        o_m_tuser;        // run_last[0]

    t_log_item   item_q[$];
    t_wire_byte  framed_q[$];
    t_log_item   next_item;
    t_log_item   seen_item;
    t_wire_byte  want;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Framing state of the predictor
    logic        rec_open = 1'b0;
    logic        rec_kind = lrf_pkg::KIND_DATA;
    logic [7:0]  data_sum = '0;
    int          msg_count = 0;
    logic        msg_done = 1'b0;

    log_record_framer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long, none at all while calm
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Work out the framed bytes that one accepted item gives and queue them
    task automatic frame_item(input t_log_item it);
        t_wire_byte burst[BURST_MAX];
        int n;
        int k;
        n = 0;
        // open a record: type, counter, timestamp high then low
        if (!rec_open) begin
            rec_open = 1'b1;
            rec_kind = it.mode;
            data_sum = '0;
            msg_count = 0;
            msg_done = 1'b0;
            burst[0] = '{(it.mode == lrf_pkg::KIND_MARKER) ? lrf_pkg::TYPE_MARKER
                                                           : lrf_pkg::TYPE_DATA, 1'b0, 1'b0};
            burst[1] = '{it.counter, 1'b0, 1'b0};
            burst[2] = '{it.stamp[15:8], 1'b0, 1'b0};
            burst[3] = '{it.stamp[7:0], 1'b0, 1'b0};
            n = 4;
        end
        if (rec_kind == lrf_pkg::KIND_DATA) begin
            // pass bytes through, close with the running sum
            if (it.present) begin
                burst[n] = '{it.pb, 1'b0, 1'b0};
                n++;
                data_sum = data_sum + it.pb;
            end
            if (it.last) begin
                burst[n] = '{data_sum, 1'b1, 1'b0};
                n++;
            end
        end else begin
            // copy message up to NUL or a full area, drop the rest
            if (it.present && !msg_done && msg_count < lrf_pkg::MESSAGE_BYTES) begin
                msg_count++;
                burst[n] = '{it.pb, msg_count == lrf_pkg::MESSAGE_BYTES, 1'b0};
                n++;
                if (it.pb == lrf_pkg::NUL_BYTE) msg_done = 1'b1;
            end
            // pad the message area on the closing item
            if (it.last) begin
                while (msg_count < lrf_pkg::MESSAGE_BYTES) begin
                    msg_count++;
                    burst[n] = '{lrf_pkg::PAD_BYTE, msg_count == lrf_pkg::MESSAGE_BYTES, 1'b0};
                    n++;
                end
            end
        end
        if (it.last) begin
            rec_open = 1'b0;
            data_sum = '0;
            msg_count = 0;
            msg_done = 1'b0;
        end
        for (k = 0; k < n; k++) begin
            burst[k].run_end = (k == n - 1);
            framed_q.push_back(burst[k]);
        end
    endtask

    task automatic add_item(input logic mode, input logic [7:0] counter,
                            input logic [15:0] stamp, input logic [7:0] pb,
                            input logic present, input logic last);
        t_log_item it;
        it = '{mode, counter, stamp, pb, present, last};
        item_q.push_back(it);
    endtask

    // One record with random content; later items carry random ignored header fields
    task automatic add_random_record(input bit long_marker);
        logic       kind;
        int         len;
        int         r;
        int         nul_pct;
        int         i;
        logic [7:0] pb;
        kind = long_marker ? lrf_pkg::KIND_MARKER : logic'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (long_marker || (kind == lrf_pkg::KIND_MARKER && r < 25)) len = $urandom_range(45, 58);
        else if (r < 35) len = 1;
        else len = $urandom_range(2, 12);
        r = $urandom_range(0, 2);
        nul_pct = (r == 0) ? 0 : ((r == 1) ? 4 : 25);
        for (i = 0; i < len; i++) begin
            pb = 8'($urandom);
            if (kind == lrf_pkg::KIND_MARKER) begin
                if ($urandom_range(0, 99) < nul_pct) pb = lrf_pkg::NUL_BYTE;
                else if (nul_pct == 0 && pb == lrf_pkg::NUL_BYTE) pb = 8'h20;
            end
            add_item((i == 0) ? kind : logic'($urandom_range(0, 1)), 8'($urandom),
                     16'($urandom), pb, $urandom_range(0, 7) != 0, i == len - 1);
        end
    endtask

    // Drive input items, holding each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (item_q.size() != 0) begin
                next_item = item_q.pop_front();
                i_s_tdata <= {next_item.pb, next_item.stamp, next_item.counter};
                i_s_tuser <= {next_item.present, next_item.mode};
                i_s_tlast <= next_item.last;
                i_s_tvalid <= 1'b1;
                if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
                send_gap <= idle_len(send_calm);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the output side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            recv_gap <= idle_len(recv_calm);
        end
    end

    // Check each output byte against the oldest framed byte, then predict from the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_open = 1'b0;
            msg_count = 0;
            framed_q.delete();
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (framed_q.size() == 0) begin
                    $display("%0t: unexpected byte, actual %h end %b run_last %b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser);
                    mismatch_count++;
                end else begin
                    want = framed_q.pop_front();
                    if (o_m_tdata !== want.value || o_m_tlast !== want.rec_end ||
                        o_m_tuser !== want.run_end) begin
                        $display({"%0t: mismatch, expected %h end %b run_last %b, ",
                                  "actual %h end %b run_last %b"},
                                 $time, want.value, want.rec_end, want.run_end,
                                 o_m_tdata, o_m_tlast, o_m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                seen_item.counter = i_s_tdata[7:0];
                seen_item.stamp = i_s_tdata[23:8];
                seen_item.pb = i_s_tdata[31:24];
                seen_item.mode = i_s_tuser[0];
                seen_item.present = i_s_tuser[1];
                seen_item.last = i_s_tlast;
                frame_item(seen_item);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int rec;
        // empty data record and empty marker record at the field extremes
        add_item(lrf_pkg::KIND_DATA, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1);
        add_item(lrf_pkg::KIND_MARKER, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
        // checksum wrap, a no-byte item mid-record, ignored header fields later on
        add_item(lrf_pkg::KIND_DATA, 8'h5A, 16'h8001, 8'hFF, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_MARKER, 8'hA5, 16'h7FFE, 8'hAA, 1'b0, 1'b0);
        add_item(lrf_pkg::KIND_MARKER, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_DATA, 8'h00, 16'h0000, 8'h03, 1'b1, 1'b1);
        // data record closed by an item with no byte
        add_item(lrf_pkg::KIND_DATA, 8'h01, 16'h1234, 8'h80, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_DATA, 8'h02, 16'h5678, 8'h00, 1'b0, 1'b1);
        // marker text, NUL, bytes after the NUL dropped
        add_item(lrf_pkg::KIND_MARKER, 8'h10, 16'hABCD, 8'h48, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_DATA, 8'hEE, 16'h0F0F, 8'h69, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_DATA, 8'h11, 16'hF0F0, lrf_pkg::NUL_BYTE, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_MARKER, 8'h22, 16'h3333, 8'h7E, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_MARKER, 8'h44, 16'h5555, 8'h41, 1'b1, 1'b1);
        // marker whose NUL arrives on the closing item
        add_item(lrf_pkg::KIND_MARKER, 8'h80, 16'h00FF, 8'h21, 1'b1, 1'b0);
        add_item(lrf_pkg::KIND_MARKER, 8'h7F, 16'hFF00, lrf_pkg::NUL_BYTE, 1'b1, 1'b1);
        // single-item marker with a byte, padded out
        add_item(lrf_pkg::KIND_MARKER, 8'hC3, 16'h3C3C, 8'hFF, 1'b1, 1'b1);
        // marker opened without a byte, closed with one
        add_item(lrf_pkg::KIND_MARKER, 8'h33, 16'h4444, 8'h00, 1'b0, 1'b0);
        add_item(lrf_pkg::KIND_DATA, 8'h66, 16'h7777, 8'h55, 1'b1, 1'b1);
        // random records, a long marker every so often
        rec = 0;
        while (item_q.size() < 520) begin
            add_random_record(rec % 10 == 0);
            rec++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the input side, then the output side, then let the pipe settle
        while (item_q.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (framed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
